/* rtl/hslrgb_pkg.sv */
package hslrgb_pkg;

    // Fraction bits of the internal values. 1.0 is 2**FRAC_BITS, so a value
    // in 0..1.0 needs one extra integer bit.
    localparam int FRAC_BITS = 16;
    localparam int VW        = FRAC_BITS + 1;

    localparam int HUE_W = 16;
    localparam int PCT_W = 14;
    localparam int OUT_W = 16;

    localparam longint unsigned ONE_L    = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF_L   = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned THIRD_L  = (ONE_L + 64'd1) / 64'd3;
    localparam longint unsigned OUT_MAX  = (64'd1 << OUT_W) - 64'd1;

    // Full-scale input codes.
    localparam longint unsigned HUE_FULL = 64'd36000;
    localparam longint unsigned PCT_FULL = 64'd10000;

    // Scaling divides v*ONE + full/2 by full. The quotient is estimated with
    // a reciprocal that is rounded down, which leaves it at most one low.
    localparam int HUE_NW = $clog2(HUE_FULL * ONE_L + HUE_FULL / 64'd2 + 64'd1);
    localparam int PCT_NW = $clog2(PCT_FULL * ONE_L + PCT_FULL / 64'd2 + 64'd1);
    localparam longint unsigned HUE_RECIP = (64'd1 << HUE_NW) / HUE_FULL;
    localparam longint unsigned PCT_RECIP = (64'd1 << PCT_NW) / PCT_FULL;
    localparam int HUE_RW = $clog2(HUE_RECIP + 64'd1);
    localparam int PCT_RW = $clog2(PCT_RECIP + 64'd1);

    // Pipeline stage positions.
    localparam int ST_SMUL    = 0;
    localparam int ST_SFIX    = 1;
    localparam int ST_PROD    = 2;
    localparam int ST_MIX     = 3;
    localparam int ST_MUL     = 4;
    localparam int ST_SUM     = 5;
    localparam int ST_OUT     = 6;
    localparam int NUM_STAGES = 7;

    typedef logic [VW-1:0] t_frac;

    typedef struct packed {
        logic [HUE_W-1:0] hue_centideg;
        logic [PCT_W-1:0] sat_centipct;
        logic [PCT_W-1:0] light_centipct;
    } t_hsl;

    typedef struct packed {
        logic [OUT_W-1:0] red_frac;
        logic [OUT_W-1:0] green_frac;
        logic [OUT_W-1:0] blue_frac;
    } t_rgb;

    // Piece of the hue-to-channel rule that applies to one channel hue.
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    typedef struct packed {
        logic mul;
        logic fix;
    } t_scale_en;

    typedef struct packed {
        logic sel;
        logic mul;
        logic sum;
        logic out;
    } t_chan_en;

endpackage

/* rtl/hsl_to_rgb_converter.sv */
// HSL to RGB color converter. Each input transaction carries hue in hundredths
// of a degree and saturation and lightness in hundredths of a percent; values
// above 36000 or 10000 are saturated. The block returns one RGB transaction
// per input, with each channel a 16-bit fraction where 65535 is full
// intensity. It is a seven-stage pipeline that takes a new pixel on every
// clock unless a stall holds it: throughput is one transaction per cycle
// while the output is not stalled. The seven register stages are
// reciprocal multiply, quotient correction, l*s product, v1/v2 formation
// with segment selection, ramp multiply, channel select and output scaling.
// Stall from the output side holds the last full stage, and a bubble
// anywhere in the pipeline is filled before the input is stalled, so the
// input is stalled only while every stage holds a transaction.
module hsl_to_rgb_converter
    import hslrgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic i_in_valid,
    input  t_hsl i_in_data,
    output logic o_in_stall,

    output logic o_out_valid,
    output t_rgb o_out_data,
    input  logic i_out_stall
);

    localparam int MW = VW + 3;
    localparam int LW = 2 * VW + 1;

    // Pipeline control. A stage can take a new transaction when it is empty
    // or when its own content moves on in the same cycle.
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES:0]   ready;
    logic [NUM_STAGES-1:0] v_in;
    logic [NUM_STAGES-1:0] load;
    logic                  in_acc;
    logic                  out_acc;

    always_comb begin
        ready[NUM_STAGES] = !i_out_stall;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            ready[i] = !r_valid[i] || ready[i+1];
        end
        v_in[0] = i_in_valid;
        for (int i = 1; i < NUM_STAGES; i++) begin
            v_in[i] = r_valid[i-1];
        end
        load = v_in & ready[NUM_STAGES-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (ready[i]) begin
                    r_valid[i] <= v_in[i];
                end
            end
        end
    end

    assign o_in_stall  = !ready[0];
    assign o_out_valid = r_valid[ST_OUT];
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    // Stages 0 and 1: saturate and scale the inputs to fractions of 1.0.
    t_scale_en scale_en;
    t_frac     h;
    t_frac     s;
    t_frac     l;

    assign scale_en.mul = load[ST_SMUL];
    assign scale_en.fix = load[ST_SFIX];

    hslrgb_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (scale_en),
        .i_hue   (i_in_data.hue_centideg),
        .i_sat   (i_in_data.sat_centipct),
        .i_light (i_in_data.light_centipct),
        .o_h     (h),
        .o_s     (s),
        .o_l     (l)
    );

    // Stage 2: the rounded l*s product, and the three channel hues wrapped
    // back into 0..1.0 (red leads green by a third, blue trails by a third).
    logic [LW-1:0] ls_prod;
    logic [VW:0]   tr_sum;
    t_frac         tr_wrap;
    t_frac         tb_wrap;

    t_frac r2_l;
    t_frac r2_s;
    t_frac r2_ls;
    t_frac r2_tr;
    t_frac r2_tg;
    t_frac r2_tb;

    always_comb begin
        ls_prod = LW'(l) * LW'(s) + LW'(HALF_L);
        tr_sum  = (VW + 1)'(h) + (VW + 1)'(THIRD_L);
        tr_wrap = (tr_sum > (VW + 1)'(ONE_L)) ? VW'(tr_sum - (VW + 1)'(ONE_L))
                                               : tr_sum[VW-1:0];
        tb_wrap = (h >= VW'(THIRD_L)) ? h - VW'(THIRD_L)
                                      : h + VW'(ONE_L - THIRD_L);
    end

    always_ff @(posedge i_clk) begin
        if (load[ST_PROD]) begin
            r2_l  <= l;
            r2_s  <= s;
            r2_ls <= ls_prod[FRAC_BITS +: VW];
            r2_tr <= tr_wrap;
            r2_tg <= h;
            r2_tb <= tb_wrap;
        end
    end

    // Stage 3: v2 = l*(1+s) below half lightness, else l+s-l*s; v1 = 2l-v2.
    // The ramp height v2-v1 is carried along for the ramp multiply.
    logic signed [MW-1:0] l_m;
    logic signed [MW-1:0] s_m;
    logic signed [MW-1:0] ls_m;
    logic signed [MW-1:0] l_dbl;
    logic signed [MW-1:0] v2;
    logic signed [MW-1:0] v1_raw;
    logic signed [MW-1:0] v1;
    logic signed [MW-1:0] d;

    t_frac       r3_v1;
    logic [VW:0] r3_v2;
    logic [VW:0] r3_d;
    t_frac       r4_v1;
    logic [VW:0] r4_v2;

    always_comb begin
        l_m    = signed'(MW'(r2_l));
        s_m    = signed'(MW'(r2_s));
        ls_m   = signed'(MW'(r2_ls));
        l_dbl  = l_m <<< 1;
        v2     = (l_dbl < signed'(MW'(ONE_L))) ? l_m + ls_m : l_m + s_m - ls_m;
        v1_raw = l_dbl - v2;
        v1     = v1_raw[MW-1] ? '0 : v1_raw;
        d      = v2 - v1;
    end

    always_ff @(posedge i_clk) begin
        if (load[ST_MIX]) begin
            r3_v1 <= v1[VW-1:0];
            r3_v2 <= v2[VW:0];
            r3_d  <= d[MW-1] ? '0 : d[VW:0];
        end
        if (load[ST_MUL]) begin
            r4_v1 <= r3_v1;
            r4_v2 <= r3_v2;
        end
    end

    // Stages 3 to 6 of each channel: segment select, ramp multiply, channel
    // select with clamp, and scaling to the 16-bit output code.
    t_chan_en         chan_en;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;

    assign chan_en.sel = load[ST_MIX];
    assign chan_en.mul = load[ST_MUL];
    assign chan_en.sum = load[ST_SUM];
    assign chan_en.out = load[ST_OUT];

    hslrgb_chan u_chan_red (
        .i_clk (i_clk),
        .i_en  (chan_en),
        .i_t   (r2_tr),
        .i_d   (r3_d),
        .i_v1  (r4_v1),
        .i_v2  (r4_v2),
        .o_val (red)
    );

    hslrgb_chan u_chan_green (
        .i_clk (i_clk),
        .i_en  (chan_en),
        .i_t   (r2_tg),
        .i_d   (r3_d),
        .i_v1  (r4_v1),
        .i_v2  (r4_v2),
        .o_val (green)
    );

    hslrgb_chan u_chan_blue (
        .i_clk (i_clk),
        .i_en  (chan_en),
        .i_t   (r2_tb),
        .i_d   (r3_d),
        .i_v1  (r4_v1),
        .i_v2  (r4_v2),
        .o_val (blue)
    );

    assign o_out_data.red_frac   = red;
    assign o_out_data.green_frac = green;
    assign o_out_data.blue_frac  = blue;

`ifndef SYNTH
    // The input is held off only when every stage is occupied.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_valid))
        else $error("input stalled while the pipeline has a free stage");

    // Transactions in flight change only by what enters and what leaves.
    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_valid) == $past($countones(r_valid))
                                    + $past(32'(in_acc)) - $past(32'(out_acc))))
        else $error("a transaction was lost or duplicated in the pipeline");

    // v1 never rises above v2, so the ramp height is never negative.
    a_v1_below_v2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ST_MIX] |-> ((VW + 1)'(r3_v1) <= r3_v2))
        else $error("v1 above v2");

    // Zero saturation is a gray: the two levels meet and the ramp is flat.
    a_gray_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load[ST_MIX] && (r2_s == '0)) |=> (r3_d == '0))
        else $error("nonzero ramp height for zero saturation");
`endif

endmodule

/* rtl/hslrgb_scale.sv */
module hslrgb_scale
    import hslrgb_pkg::*;
(
    input  logic             i_clk,
    input  t_scale_en        i_en,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [PCT_W-1:0] i_sat,
    input  logic [PCT_W-1:0] i_light,
    output t_frac            o_h,
    output t_frac            o_s,
    output t_frac            o_l
);

    localparam int HPW = HUE_NW + HUE_RW;
    localparam int PPW = PCT_NW + PCT_RW;

    logic [HUE_W-1:0]  hue_clip;
    logic [HUE_NW-1:0] hue_num;
    logic [HPW-1:0]    hue_prod;
    logic [HUE_NW-1:0] hue_back;
    logic [HUE_NW-1:0] hue_rem;

    logic [PCT_W-1:0]  pct_in   [2];
    logic [PCT_W-1:0]  pct_clip [2];
    logic [PCT_NW-1:0] pct_num  [2];
    logic [PPW-1:0]    pct_prod [2];
    logic [PCT_NW-1:0] pct_back [2];
    logic [PCT_NW-1:0] pct_rem  [2];

    logic [HUE_NW-1:0] r_hue_num;
    t_frac             r_hue_q;
    logic [PCT_NW-1:0] r_pct_num [2];
    t_frac             r_pct_q   [2];
    t_frac             r_h;
    t_frac             r_pct     [2];

    // Saturate, form v*ONE + full/2 and multiply by the reciprocal.
    always_comb begin
        hue_clip = (i_hue > HUE_W'(HUE_FULL)) ? HUE_W'(HUE_FULL) : i_hue;
        hue_num  = (HUE_NW'(hue_clip) << FRAC_BITS) + HUE_NW'(HUE_FULL / 64'd2);
        hue_prod = HPW'(hue_num) * HPW'(HUE_RECIP);

        pct_in[0] = i_sat;
        pct_in[1] = i_light;
        for (int i = 0; i < 2; i++) begin
            pct_clip[i] = (pct_in[i] > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_in[i];
            pct_num[i]  = (PCT_NW'(pct_clip[i]) << FRAC_BITS)
                        + PCT_NW'(PCT_FULL / 64'd2);
            pct_prod[i] = PPW'(pct_num[i]) * PPW'(PCT_RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_hue_num <= hue_num;
            r_hue_q   <= hue_prod[HUE_NW +: VW];
            for (int i = 0; i < 2; i++) begin
                r_pct_num[i] <= pct_num[i];
                r_pct_q[i]   <= pct_prod[i][PCT_NW +: VW];
            end
        end
    end

    // The estimate is at most one low: a remainder of a full divisor or more
    // bumps it by one.
    always_comb begin
        hue_back = HUE_NW'(r_hue_q) * HUE_NW'(HUE_FULL);
        hue_rem  = r_hue_num - hue_back;
        for (int i = 0; i < 2; i++) begin
            pct_back[i] = PCT_NW'(r_pct_q[i]) * PCT_NW'(PCT_FULL);
            pct_rem[i]  = r_pct_num[i] - pct_back[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.fix) begin
            r_h <= (hue_rem >= HUE_NW'(HUE_FULL)) ? r_hue_q + VW'(1) : r_hue_q;
            for (int i = 0; i < 2; i++) begin
                r_pct[i] <= (pct_rem[i] >= PCT_NW'(PCT_FULL))
                          ? r_pct_q[i] + VW'(1) : r_pct_q[i];
            end
        end
    end

    assign o_h = r_h;
    assign o_s = r_pct[0];
    assign o_l = r_pct[1];

endmodule

/* rtl/hslrgb_chan.sv */
module hslrgb_chan
    import hslrgb_pkg::*;
(
    input  logic             i_clk,
    input  t_chan_en         i_en,
    input  t_frac            i_t,
    input  logic [VW:0]      i_d,
    input  t_frac            i_v1,
    input  logic [VW:0]      i_v2,
    output logic [OUT_W-1:0] o_val
);

    localparam int SW = VW + 2;
    localparam int PW = 2 * VW + 2;
    localparam int CW = VW + 2;
    localparam int OW = VW + OUT_W + 1;

    logic [SW-1:0]    two_t;
    logic [SW-1:0]    three_t;
    logic [SW-1:0]    six_t;
    t_seg             seg;
    t_frac            k;
    logic [PW-1:0]    prod;
    logic [CW-1:0]    c_raw;
    logic [OW-1:0]    scaled;

    t_seg             r_seg;
    t_frac            r_k;
    t_seg             r_seg2;
    logic [VW:0]      r_p;
    t_frac            r_c;
    logic [OUT_W-1:0] r_out;

    // Pick the piece of the rule and the ramp position for this hue.
    always_comb begin
        two_t   = SW'(i_t) << 1;
        three_t = two_t + SW'(i_t);
        six_t   = three_t << 1;
        seg     = SEG_LOW;
        k       = '0;
        priority if (six_t < SW'(ONE_L)) begin
            seg = SEG_RISE;
            k   = six_t[VW-1:0];
        end else if (two_t < SW'(ONE_L)) begin
            seg = SEG_HIGH;
        end else if (three_t < SW'(2 * ONE_L)) begin
            seg = SEG_FALL;
            k   = VW'(SW'(4 * ONE_L) - six_t);
        end else begin
            seg = SEG_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sel) begin
            r_seg <= seg;
            r_k   <= k;
        end
    end

    assign prod = PW'(i_d) * PW'(r_k) + PW'(HALF_L);

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_seg2 <= r_seg;
            r_p    <= prod[FRAC_BITS +: VW + 1];
        end
    end

    always_comb begin
        unique case (r_seg2)
            SEG_RISE, SEG_FALL: c_raw = CW'(i_v1) + CW'(r_p);
            SEG_HIGH:           c_raw = CW'(i_v2);
            SEG_LOW:            c_raw = CW'(i_v1);
            default:            c_raw = CW'(i_v1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_c <= (c_raw > CW'(ONE_L)) ? VW'(ONE_L) : c_raw[VW-1:0];
        end
    end

    assign scaled = OW'(r_c) * OW'(OUT_MAX) + OW'(HALF_L);

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_out <= scaled[FRAC_BITS +: OUT_W];
        end
    end

    assign o_val = r_out;

endmodule
